### src/ksbl_pkg.sv
// Shared types and constants for the k-th successor block.
// Holds the transaction payload structs, the sequencer state type and the
// control/status structs. Depends on nothing.
`default_nettype none

package ksbl_pkg;

    localparam int NODES   = 1024;
    localparam int LEVELS  = 30;
    localparam int NODE_W  = 10;
    localparam int CNT_W   = 11;
    localparam int JUMP_W  = 30;
    localparam int LEVEL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int QLEVELS = (LEVELS < JUMP_W) ? LEVELS : JUMP_W;
    localparam int RAM_AW  = LEVEL_W + NODE_W;
    localparam int RAM_DEPTH = LEVELS * NODES;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_BUILD = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] successor;
        logic [JUMP_W-1:0] jump_count;
    } ksbl_in_t;

    typedef struct packed {
        logic [NODE_W-1:0] reached_node;
        logic              not_ready;
    } ksbl_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BRD0,
        ST_BRD1,
        ST_BWR,
        ST_BFIN,
        ST_QRY,
        ST_QFIN,
        ST_DONE
    } ksbl_state_t;

    typedef struct packed {
        logic             start;
        ksbl_in_t         item;
        logic [CNT_W-1:0] nc;
        logic             table_ready;
        logic             out_free;
    } ksbl_cmd_t;

    typedef struct packed {
        logic      idle;
        logic      load_wr;
        logic      build_done;
        logic      res_valid;
        ksbl_out_t res;
    } ksbl_stat_t;

endpackage

`default_nettype wire

### src/ksbl_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
`default_nettype none

module ksbl_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### src/ksbl_engine.sv
// Sequencer for loads, table builds and bit-serial queries over the jump table.
// Uses ksbl_pkg and instantiates ksbl_ram for the jump table.
`default_nettype none

module ksbl_engine (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire ksbl_pkg::ksbl_cmd_t cmd,
    output ksbl_pkg::ksbl_stat_t     stat
);

    ksbl_pkg::ksbl_state_t state_reg, state_next;

    logic [ksbl_pkg::LEVEL_W-1:0] lv_reg, lv_next;
    logic [ksbl_pkg::NODE_W-1:0]  j_reg, j_next;
    logic [ksbl_pkg::NODE_W-1:0]  x_reg, x_next;
    logic                         take_reg, take_next;
    logic [ksbl_pkg::JUMP_W-1:0]  k_reg, k_next;
    ksbl_pkg::ksbl_out_t          res_reg, res_next;

    logic                         ram_we;
    logic [ksbl_pkg::RAM_AW-1:0]  ram_waddr;
    logic [ksbl_pkg::NODE_W-1:0]  ram_wdata;
    logic                         ram_re;
    logic [ksbl_pkg::RAM_AW-1:0]  ram_raddr;
    logic [ksbl_pkg::NODE_W-1:0]  ram_rdata;

    logic [ksbl_pkg::NODE_W-1:0]  cur_x;
    logic [ksbl_pkg::LEVEL_W-1:0] lv_prev;
    logic [ksbl_pkg::CNT_W-1:0]   nc_m1;
    logic                         last_node;
    logic                         node_ok;
    logic                         succ_ok;

    ksbl_ram #(
        .WIDTH(ksbl_pkg::NODE_W),
        .DEPTH(ksbl_pkg::RAM_DEPTH)
    ) u_table (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign cur_x     = take_reg ? ram_rdata : x_reg;
    assign lv_prev   = lv_reg - ksbl_pkg::LEVEL_W'(1);
    assign nc_m1     = cmd.nc - ksbl_pkg::CNT_W'(1);
    assign last_node = (j_reg == nc_m1[ksbl_pkg::NODE_W-1:0]);
    assign node_ok   = ({1'b0, cmd.item.node} < cmd.nc);
    assign succ_ok   = ({1'b0, cmd.item.successor} < cmd.nc);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ksbl_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        lv_reg   <= lv_next;
        j_reg    <= j_next;
        x_reg    <= x_next;
        take_reg <= take_next;
        k_reg    <= k_next;
        res_reg  <= res_next;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ksbl_pkg::ST_IDLE: begin
                if (cmd.start) begin
                    case (cmd.item.opcode)
                        ksbl_pkg::OP_BUILD: begin
                            state_next = (ksbl_pkg::LEVELS > 1) ? ksbl_pkg::ST_BRD0
                                                                : ksbl_pkg::ST_BFIN;
                        end
                        ksbl_pkg::OP_QUERY: begin
                            state_next = (cmd.table_ready && node_ok) ? ksbl_pkg::ST_QRY
                                                                      : ksbl_pkg::ST_DONE;
                        end
                        default: state_next = ksbl_pkg::ST_IDLE;
                    endcase
                end
            end
            ksbl_pkg::ST_BRD0: state_next = ksbl_pkg::ST_BRD1;
            ksbl_pkg::ST_BRD1: state_next = ksbl_pkg::ST_BWR;
            ksbl_pkg::ST_BWR: begin
                if (last_node && lv_reg == ksbl_pkg::LEVEL_W'(ksbl_pkg::LEVELS - 1)) begin
                    state_next = ksbl_pkg::ST_BFIN;
                end else begin
                    state_next = ksbl_pkg::ST_BRD0;
                end
            end
            ksbl_pkg::ST_BFIN: state_next = ksbl_pkg::ST_IDLE;
            ksbl_pkg::ST_QRY: begin
                if (lv_reg == ksbl_pkg::LEVEL_W'(ksbl_pkg::QLEVELS - 1)) begin
                    state_next = ksbl_pkg::ST_QFIN;
                end
            end
            ksbl_pkg::ST_QFIN: state_next = ksbl_pkg::ST_DONE;
            ksbl_pkg::ST_DONE: begin
                if (cmd.out_free) begin
                    state_next = ksbl_pkg::ST_IDLE;
                end
            end
            default: state_next = ksbl_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        lv_next   = lv_reg;
        j_next    = j_reg;
        x_next    = x_reg;
        take_next = take_reg;
        k_next    = k_reg;
        res_next  = res_reg;
        ram_we    = 1'b0;
        ram_waddr = {lv_reg, j_reg};
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = {lv_prev, j_reg};

        stat            = '0;
        stat.idle       = (state_reg == ksbl_pkg::ST_IDLE);
        stat.build_done = (state_reg == ksbl_pkg::ST_BFIN);
        stat.res_valid  = (state_reg == ksbl_pkg::ST_DONE);
        stat.res        = res_reg;

        case (state_reg)
            ksbl_pkg::ST_IDLE: begin
                lv_next   = '0;
                j_next    = '0;
                x_next    = cmd.item.node;
                take_next = 1'b0;
                k_next    = cmd.item.jump_count;
                if (cmd.start) begin
                    case (cmd.item.opcode)
                        ksbl_pkg::OP_LOAD: begin
                            if (node_ok && succ_ok) begin
                                ram_we       = 1'b1;
                                ram_waddr    = {ksbl_pkg::LEVEL_W'(0), cmd.item.node};
                                ram_wdata    = cmd.item.successor;
                                stat.load_wr = 1'b1;
                            end
                        end
                        ksbl_pkg::OP_BUILD: begin
                            lv_next = ksbl_pkg::LEVEL_W'(1);
                        end
                        ksbl_pkg::OP_QUERY: begin
                            res_next.reached_node = '0;
                            res_next.not_ready    = 1'b1;
                        end
                        default: begin
                            lv_next = '0;
                        end
                    endcase
                end
            end
            ksbl_pkg::ST_BRD0: begin
                ram_re    = 1'b1;
                ram_raddr = {lv_prev, j_reg};
            end
            ksbl_pkg::ST_BRD1: begin
                ram_re    = 1'b1;
                ram_raddr = {lv_prev, ram_rdata};
            end
            ksbl_pkg::ST_BWR: begin
                ram_we    = 1'b1;
                ram_waddr = {lv_reg, j_reg};
                ram_wdata = ram_rdata;
                if (last_node) begin
                    j_next  = '0;
                    lv_next = lv_reg + ksbl_pkg::LEVEL_W'(1);
                end else begin
                    j_next = j_reg + ksbl_pkg::NODE_W'(1);
                end
            end
            ksbl_pkg::ST_QRY: begin
                ram_re    = 1'b1;
                ram_raddr = {lv_reg, cur_x};
                x_next    = cur_x;
                take_next = k_reg[0];
                k_next    = k_reg >> 1;
                lv_next   = lv_reg + ksbl_pkg::LEVEL_W'(1);
            end
            ksbl_pkg::ST_QFIN: begin
                res_next.reached_node = cur_x;
                res_next.not_ready    = 1'b0;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/kth_successor_binary_lifting.sv
// Load: the entry is written in the cycle the command is accepted. Query: one table level
// per cycle as the jump count shifts out bit by bit; when the table is not ready or the
// start node is out of range, the walk is skipped and the answer is marked not ready.
// Build: three jump-table accesses per entry, on every level above level 0.
// One transaction at a time; a finished result waits in the engine until the output register is free.
// Reset clears control state, sets node_count to 1024 and marks the table not ready;
// the table contents stay undefined until written and are not cleared.
`default_nettype none

module kth_successor_binary_lifting (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire ksbl_pkg::ksbl_in_t              s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output ksbl_pkg::ksbl_out_t                  m_data,
    input  wire logic                            cfg_wr_en,
    input  wire logic [ksbl_pkg::CNT_W-1:0]      cfg_wr_data
);

    logic [ksbl_pkg::CNT_W-1:0] node_count_reg, node_count_next;
    logic                       table_ready_reg, table_ready_next;
    logic                       m_valid_reg, m_valid_next;
    ksbl_pkg::ksbl_out_t        m_data_reg, m_data_next;
    logic [ksbl_pkg::CNT_W-1:0] nc;
    logic                       out_free;
    ksbl_pkg::ksbl_cmd_t        cmd;
    ksbl_pkg::ksbl_stat_t       stat;

    always_comb begin
        if (node_count_reg == '0) begin
            nc = ksbl_pkg::CNT_W'(1);
        end else if (node_count_reg > ksbl_pkg::CNT_W'(ksbl_pkg::NODES)) begin
            nc = ksbl_pkg::CNT_W'(ksbl_pkg::NODES);
        end else begin
            nc = node_count_reg;
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = stat.idle;

    always_comb begin
        cmd.start       = s_valid && s_ready;
        cmd.item        = s_data;
        cmd.nc          = nc;
        cmd.table_ready = table_ready_reg;
        cmd.out_free    = out_free;
    end

    ksbl_engine u_engine (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cmd    (cmd),
        .stat   (stat)
    );

    always_comb begin
        node_count_next  = node_count_reg;
        table_ready_next = table_ready_reg;
        if (cfg_wr_en) begin
            node_count_next  = cfg_wr_data;
            table_ready_next = 1'b0;
        end else if (stat.load_wr) begin
            table_ready_next = 1'b0;
        end else if (stat.build_done) begin
            table_ready_next = 1'b1;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (stat.res_valid && out_free) begin
            m_valid_next = 1'b1;
            m_data_next  = stat.res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg  <= ksbl_pkg::CNT_W'(ksbl_pkg::NODES);
            table_ready_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            node_count_reg  <= node_count_next;
            table_ready_reg <= table_ready_next;
            m_valid_reg     <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_build_sets_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.build_done && !cfg_wr_en |=> table_ready_reg)
        else $error("table not marked ready after build");

    a_load_clears_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.load_wr |=> !table_ready_reg)
        else $error("table still marked ready after load");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.res_valid && !out_free |=> stat.res_valid && $stable(stat.res))
        else $error("pending result lost while output register full");

    a_result_moved: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.res_valid && out_free |=> m_valid && m_data == $past(stat.res))
        else $error("result not moved into output register");

endmodule

`default_nettype wire

### bench/successor_checker.sv
// Checker for the k-th successor block: watches the command, answer and register ports.
// Keeps its own successor graph and jump table and compares every answer in order.
// Depends on ksbl_pkg.
`timescale 1ns / 100ps

module successor_checker (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    input  wire logic                       s_ready,
    input  wire ksbl_pkg::ksbl_in_t         s_data,
    input  wire logic                       m_valid,
    input  wire logic                       m_ready,
    input  wire ksbl_pkg::ksbl_out_t        m_data,
    input  wire logic                       cfg_wr_en,
    input  wire logic [ksbl_pkg::CNT_W-1:0] cfg_wr_data,
    output int                              fail_count,
    output int                              open_answers,
    output int                              answers_checked,
    output int                              not_ready_answers
);

    logic [ksbl_pkg::NODE_W-1:0] hop [ksbl_pkg::NODES][ksbl_pkg::LEVELS];
    logic [ksbl_pkg::CNT_W-1:0]  node_limit;
    logic                        graph_ready;
    ksbl_pkg::ksbl_out_t         expected_answers [$];

    initial begin
        fail_count = 0;
        open_answers = 0;
        answers_checked = 0;
        not_ready_answers = 0;
        node_limit = ksbl_pkg::CNT_W'(ksbl_pkg::NODES);
        graph_ready = 1'b0;
        for (int n = 0; n < ksbl_pkg::NODES; n++) begin
            for (int l = 0; l < ksbl_pkg::LEVELS; l++) begin
                hop[n][l] = '0;
            end
        end
    end

    function automatic int active_nodes(input logic [ksbl_pkg::CNT_W-1:0] value);
        if (value == 0) return 1;
        if (value > ksbl_pkg::NODES) return ksbl_pkg::NODES;
        return int'(value);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        $display("[%0t] mismatch: %s, got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic track_command(input ksbl_pkg::ksbl_in_t cmd);
        int                          nc;
        int                          lv;
        int                          j;
        logic [ksbl_pkg::NODE_W-1:0] here;
        ksbl_pkg::ksbl_out_t         answer;
        nc = active_nodes(node_limit);
        case (cmd.opcode)
            ksbl_pkg::OP_LOAD: begin
                if (cmd.node < nc && cmd.successor < nc) begin
                    hop[cmd.node][0] = cmd.successor;
                    graph_ready = 1'b0;
                end
            end
            ksbl_pkg::OP_BUILD: begin
                for (lv = 1; lv < ksbl_pkg::LEVELS; lv++) begin
                    for (j = 0; j < nc; j++) begin
                        hop[j][lv] = hop[hop[j][lv-1]][lv-1];
                    end
                end
                graph_ready = 1'b1;
            end
            ksbl_pkg::OP_QUERY: begin
                if (!graph_ready || cmd.node >= nc) begin
                    answer.reached_node = '0;
                    answer.not_ready = 1'b1;
                end else begin
                    here = cmd.node;
                    for (lv = 0; lv < ksbl_pkg::QLEVELS; lv++) begin
                        if (cmd.jump_count[lv]) here = hop[here][lv];
                    end
                    answer.reached_node = here;
                    answer.not_ready = 1'b0;
                end
                expected_answers = {expected_answers, answer};
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_answer(input ksbl_pkg::ksbl_out_t got);
        ksbl_pkg::ksbl_out_t want;
        if (expected_answers.size() == 0) begin
            report_mismatch("answer with no query waiting, reached_node", got.reached_node, -1);
        end else begin
            want = expected_answers.pop_front();
            answers_checked++;
            if (want.not_ready) not_ready_answers++;
            if (got.reached_node !== want.reached_node) begin
                report_mismatch("reached_node", got.reached_node, want.reached_node);
            end
            if (got.not_ready !== want.not_ready) begin
                report_mismatch("not_ready", got.not_ready, want.not_ready);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            node_limit = ksbl_pkg::CNT_W'(ksbl_pkg::NODES);
            graph_ready = 1'b0;
            expected_answers.delete();
        end else begin
            if (m_valid && m_ready) check_answer(m_data);
            if (cfg_wr_en) begin
                node_limit = cfg_wr_data;
                graph_ready = 1'b0;
            end
            if (s_valid && s_ready) track_command(s_data);
        end
        open_answers = expected_answers.size();
    end

endmodule

### bench/testbench.sv
// Top of the bench for kth_successor_binary_lifting: clock, reset, command stimulus,
// answer-side back-pressure, watchdog and verdict. Depends on ksbl_pkg,
// successor_checker and the block itself.
`timescale 1ns / 100ps

module testbench;

    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int QUIET_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 40;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    ksbl_pkg::ksbl_in_t         s_data;
    logic                       m_valid;
    logic                       m_ready;
    ksbl_pkg::ksbl_out_t        m_data;
    logic                       cfg_wr_en;
    logic [ksbl_pkg::CNT_W-1:0] cfg_wr_data;

    int fail_count;
    int open_answers;
    int answers_checked;
    int not_ready_answers;

    int send_idle;
    int recv_stall;
    int hold_request;
    int eff_nodes;
    bit stale;
    int quiet_cycles;
    int n_loads;
    int n_builds;
    int n_queries;
    int n_spare;
    int n_settings;

    kth_successor_binary_lifting uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    successor_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data           (s_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data           (m_data),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .fail_count       (fail_count),
        .open_answers     (open_answers),
        .answers_checked  (answers_checked),
        .not_ready_answers(not_ready_answers)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // The receiver counts down a requested hold-off itself, then stalls at random.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                m_ready = 1'b0;
                hold_request--;
            end else begin
                m_ready = ($urandom_range(99) >= recv_stall);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic set_mode(input int mode);
        case (mode % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 58; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 58; end
            default: begin send_idle = 22; recv_stall = 22; end
        endcase
    endtask

    task automatic send_command(input logic [1:0] op, input int node, input int succ,
                                input logic [ksbl_pkg::JUMP_W-1:0] jump);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data.opcode = op;
        s_data.node = ksbl_pkg::NODE_W'(node);
        s_data.successor = ksbl_pkg::NODE_W'(succ);
        s_data.jump_count = jump;
        do @(posedge aclk); while (!s_ready);
        case (op)
            ksbl_pkg::OP_LOAD: begin
                n_loads++;
                if (node < eff_nodes && succ < eff_nodes) stale = 1'b1;
            end
            ksbl_pkg::OP_BUILD: begin
                n_builds++;
                stale = 1'b0;
            end
            ksbl_pkg::OP_QUERY: n_queries++;
            default: n_spare++;
        endcase
    endtask

    task automatic set_node_count(input logic [ksbl_pkg::CNT_W-1:0] value);
        @(negedge aclk);
        s_valid = 1'b0;
        wait (open_answers == 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        eff_nodes = (value == 0) ? 1 :
                    ((value > ksbl_pkg::NODES) ? ksbl_pkg::NODES : int'(value));
        stale = 1'b1;
        n_settings++;
    endtask

    function automatic logic [ksbl_pkg::JUMP_W-1:0] pick_jump();
        case ($urandom_range(3))
            0: return ksbl_pkg::JUMP_W'($urandom());
            1: return ksbl_pkg::JUMP_W'($urandom_range(64));
            2: return ksbl_pkg::JUMP_W'(1) << $urandom_range(ksbl_pkg::JUMP_W - 1);
            default: return {ksbl_pkg::JUMP_W{1'b1}};
        endcase
    endfunction

    task automatic random_command();
        int r;
        int nd;
        int sc;
        r = $urandom_range(99);
        if (r < 5) begin
            send_command(OP_SPARE, $urandom_range(1023), $urandom_range(1023), pick_jump());
        end else if (r < 25) begin
            if ($urandom_range(99) < 85) begin
                nd = $urandom_range(eff_nodes - 1);
                sc = $urandom_range(eff_nodes - 1);
            end else begin
                nd = $urandom_range(1023);
                sc = $urandom_range(1023);
            end
            send_command(ksbl_pkg::OP_LOAD, nd, sc, ksbl_pkg::JUMP_W'($urandom()));
        end else if (eff_nodes <= 64 && (r < 32 || (stale && r < 45))) begin
            send_command(ksbl_pkg::OP_BUILD, $urandom_range(1023), $urandom_range(1023),
                         ksbl_pkg::JUMP_W'($urandom()));
        end else begin
            nd = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(eff_nodes - 1);
            send_command(ksbl_pkg::OP_QUERY, nd, $urandom_range(1023), pick_jump());
        end
    endtask

    // A phase writes the register, checks that the table reads as not ready, optionally
    // loads and builds a complete graph, optionally queues queries at a held receiver,
    // then mixes commands and ends on a query so the block is idle once that answer is back.
    task automatic run_phase(input logic [ksbl_pkg::CNT_W-1:0] value, input int mixed,
                             input bit load_all, input bit squeeze, input int mode);
        int n;
        set_mode(mode);
        set_node_count(value);
        send_command(ksbl_pkg::OP_QUERY, 0, 0, pick_jump());
        if (load_all) begin
            for (n = 0; n < eff_nodes; n++) begin
                send_command(ksbl_pkg::OP_LOAD, n, $urandom_range(eff_nodes - 1),
                             ksbl_pkg::JUMP_W'($urandom()));
            end
            send_command(ksbl_pkg::OP_BUILD, 0, 0, '0);
        end
        if (squeeze) begin
            send_idle = 0;
            send_command(ksbl_pkg::OP_QUERY, $urandom_range(eff_nodes - 1), 0, pick_jump());
            hold_request = 500;
            for (n = 0; n < 12; n++) begin
                send_command(ksbl_pkg::OP_QUERY, $urandom_range(eff_nodes - 1), 0,
                             pick_jump());
            end
            set_mode(mode);
        end
        for (n = 0; n < mixed; n++) begin
            random_command();
        end
        send_command(ksbl_pkg::OP_QUERY, $urandom_range(eff_nodes - 1), 0, pick_jump());
    endtask

    initial begin
        int p;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        send_idle = 0;
        recv_stall = 0;
        hold_request = 0;
        eff_nodes = ksbl_pkg::NODES;
        stale = 1'b1;
        quiet_cycles = 0;
        n_loads = 0;
        n_builds = 0;
        n_queries = 0;
        n_spare = 0;
        n_settings = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed commands at the reset setting of 1024 nodes, before any build.
        send_command(ksbl_pkg::OP_QUERY, 0, 0, '0);
        send_command(ksbl_pkg::OP_QUERY, 1023, 1023, {ksbl_pkg::JUMP_W{1'b1}});
        send_command(OP_SPARE, 1023, 1023, {ksbl_pkg::JUMP_W{1'b1}});
        send_command(ksbl_pkg::OP_LOAD, 1023, 1023, '0);
        send_command(ksbl_pkg::OP_LOAD, 0, 0, {ksbl_pkg::JUMP_W{1'b1}});
        send_command(ksbl_pkg::OP_QUERY, 512, 0, '0);

        // Directed commands on a four-node ring.
        set_node_count(ksbl_pkg::CNT_W'(4));
        send_command(ksbl_pkg::OP_LOAD, 0, 1, '0);
        send_command(ksbl_pkg::OP_LOAD, 1, 2, '0);
        send_command(ksbl_pkg::OP_LOAD, 2, 3, '0);
        send_command(ksbl_pkg::OP_LOAD, 3, 0, '0);
        send_command(ksbl_pkg::OP_QUERY, 0, 0, ksbl_pkg::JUMP_W'(1));
        send_command(ksbl_pkg::OP_BUILD, 0, 0, '0);
        send_command(ksbl_pkg::OP_QUERY, 0, 0, '0);
        send_command(ksbl_pkg::OP_QUERY, 1, 0, {ksbl_pkg::JUMP_W{1'b1}});
        send_command(ksbl_pkg::OP_QUERY, 3, 0,
                     ksbl_pkg::JUMP_W'(1) << (ksbl_pkg::JUMP_W - 1));
        send_command(ksbl_pkg::OP_LOAD, 1023, 0, '0);
        send_command(ksbl_pkg::OP_LOAD, 0, 1023, '0);
        send_command(ksbl_pkg::OP_QUERY, 2, 0, ksbl_pkg::JUMP_W'(5));
        send_command(ksbl_pkg::OP_QUERY, 4, 0, ksbl_pkg::JUMP_W'(1));
        send_command(ksbl_pkg::OP_QUERY, 1023, 0, ksbl_pkg::JUMP_W'(1));
        send_command(ksbl_pkg::OP_LOAD, 2, 2, '0);
        send_command(ksbl_pkg::OP_QUERY, 1, 0, ksbl_pkg::JUMP_W'(3));
        send_command(ksbl_pkg::OP_BUILD, 0, 0, '0);
        send_command(ksbl_pkg::OP_QUERY, 1, 0, ksbl_pkg::JUMP_W'(3));

        run_phase(ksbl_pkg::CNT_W'(2047), 40, 1'b1, 1'b0, 1);
        run_phase(ksbl_pkg::CNT_W'(ksbl_pkg::NODES), 30, 1'b0, 1'b0, 2);
        run_phase(ksbl_pkg::CNT_W'(0), 40, 1'b1, 1'b0, 3);
        run_phase(ksbl_pkg::CNT_W'(1), 40, 1'b1, 1'b0, 0);
        run_phase(ksbl_pkg::CNT_W'(2), 55, 1'b1, 1'b1, 1);
        for (p = 0; p < 4; p++) begin
            run_phase(ksbl_pkg::CNT_W'($urandom_range(3, 24)), 55, 1'b1, 1'b0, p);
        end

        @(negedge aclk);
        s_valid = 1'b0;
        wait (open_answers == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d loads, %0d builds, %0d queries and %0d unused-opcode commands",
                 n_loads, n_builds, n_queries, n_spare);
        $display("over %0d node counts; %0d answers checked, %0d of them not ready.",
                 n_settings, answers_checked, not_ready_answers);
        if (fail_count == 0 && open_answers == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches, %0d answers missing", fail_count, open_answers);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### sim.f
src/ksbl_pkg.sv
src/ksbl_ram.sv
src/ksbl_engine.sv
src/kth_successor_binary_lifting.sv
bench/successor_checker.sv
bench/testbench.sv
